FILE: rtl/core/array_tip_classifier_with_dictionary_unit_assert.svh
// Assertion macros for the tip classifier.
`ifndef ARRAY_TIP_CLASSIFIER_WITH_DICTIONARY_UNIT_ASSERT_SVH
`define ARRAY_TIP_CLASSIFIER_WITH_DICTIONARY_UNIT_ASSERT_SVH
// Implication checked on every edge outside reset.
`define ATC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ATC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/core/atcd_pkg.sv
// Package: constants, types and helpers of the tip classifier.
package atcd_pkg;
	localparam int MAX_LEN = 8;
	localparam int DICT_ENTRIES = 256;
	localparam int VALUE_BITS = 32;
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int ID_W = $clog2(DICT_ENTRIES);
	localparam int FILL_W = $clog2(DICT_ENTRIES + 1);
	localparam int ELEM_W = 33;
	localparam int SUM_W = 36;
	localparam int DADDR_W = ID_W + IDX_W;
	localparam int DDEPTH = DICT_ENTRIES * MAX_LEN;

	localparam logic [1:0] KIND_COUNT = 2'd1;
	localparam logic [1:0] KIND_LIKE = 2'd2;
	localparam logic [1:0] TIP_ZERO = 2'd0;
	localparam logic [1:0] TIP_SP1 = 2'd1;
	localparam logic [1:0] TIP_SP2 = 2'd2;
	localparam logic [1:0] TIP_GEN = 2'd3;
	localparam logic [0:0] REG_KIND = 1'b0;
	localparam logic [0:0] REG_LEN = 1'b1;

	typedef struct packed {
		logic clear;
		logic collect;
		logic [ID_W-1:0] entry;
		logic [IDX_W-1:0] elem;
		logic cmp_en;
		logic cmp_first;
		logic wr_en;
		logic hit;
		logic full;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic special;
		logic bad;
		logic [LEN_W-1:0] len;
		logic all_match;
		logic [ELEM_W-1:0] cur_elem;
	} sts_t;
endpackage

FILE: rtl/core/array_tip_classifier_with_dictionary_unit.sv
// Top level of the array tip classifier with dictionary.
//  channel | dir | contents
//  s       | in  | tdata {sample_index, element_value}, tuser {record_missing, element_missing}, tlast
//  m       | out | tdata result fields, tuser dict flags
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// One beat per cycle while collecting; after the last beat a decide state, then a read
// and a compare state per element of each stored entry searched and a write state per
// element to insert, set by the single dictionary RAM read port, then an emit state. Reset
// clears the dictionary fill count; no clearing pass. A held result stalls only the next array's emit.
module array_tip_classifier_with_dictionary_unit (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [47:0] s_tdata, // element_value, sample_index
	input logic [1:0] s_tuser, // element_missing, record_missing
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [127:0] m_tdata, // tip, position, payload_a, payload_b, payload_count, dict_id, element_sum
	output logic [5:0] m_tuser, // uses_dict, dict_new, entry_width, dict_full, sum_valid
	input logic cfg_we,
	input logic cfg_index,
	input logic [3:0] cfg_data
);
	import atcd_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [1:0] kind_q;
	logic [3:0] elen_q;
	logic [1:0] tip, payload_count, entry_width;
	logic [15:0] position;
	logic [31:0] payload_a, payload_b;
	logic uses_dict, dict_new, dict_full, sum_valid;
	logic [7:0] dict_id;
	logic signed [35:0] element_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0; elen_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KIND) kind_q <= cfg_data[1:0];
			if (cfg_index == REG_LEN) elen_q <= cfg_data;
		end
	end

	atcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.last_element(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.sts(sts), .cmd(cmd)
	);

	atcd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.element_value(s_tdata[31:0]), .element_missing(s_tuser[0]),
		.record_missing(s_tuser[1]), .sample_index(s_tdata[47:32]),
		.field_kind(kind_q), .expected_length(elen_q),
		.tip(tip), .position(position), .payload_a(payload_a), .payload_b(payload_b),
		.payload_count(payload_count), .uses_dict(uses_dict), .dict_id(dict_id),
		.dict_new(dict_new), .entry_width(entry_width), .dict_full(dict_full),
		.element_sum(element_sum), .sum_valid(sum_valid)
	);

	assign m_tdata = {element_sum, dict_id, payload_count,
		payload_b, payload_a, position, tip};
	assign m_tuser = {sum_valid, dict_full, entry_width, dict_new, uses_dict};
endmodule

FILE: rtl/core/atcd_ram.sv
// Generic single-port write, single read RAM with registered read.
module atcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/atcd_datapath.sv
// Datapath: array collection, tip classification, dictionary compare and result register.
module atcd_datapath (
	input logic clk,
	input logic arst_n,
	input atcd_pkg::cmd_t cmd,
	output atcd_pkg::sts_t sts,
	input logic [31:0] element_value,
	input logic element_missing,
	input logic record_missing,
	input logic [15:0] sample_index,
	input logic [1:0] field_kind,
	input logic [3:0] expected_length,
	output logic [1:0] tip,
	output logic [15:0] position,
	output logic [31:0] payload_a,
	output logic [31:0] payload_b,
	output logic [1:0] payload_count,
	output logic uses_dict,
	output logic [7:0] dict_id,
	output logic dict_new,
	output logic [1:0] entry_width,
	output logic dict_full,
	output logic signed [35:0] element_sum,
	output logic sum_valid
);
	import atcd_pkg::*;

	logic [ELEM_W-1:0] buf_q [MAX_LEN];
	logic [LEN_W-1:0] cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic zero_q, long_q, rmiss_q, match_q;
	logic [31:0] maxmag_q;
	logic [LEN_W-1:0] dlen_rd;
	logic [ELEM_W-1:0] drd;
	logic [15:0] pos_q;

	logic signed [VALUE_BITS-1:0] v;
	logic signed [32:0] v33, mag33;
	logic signed [32:0] e0, e1, e2;
	logic signed [37:0] b15;
	logic like_ok, cnt_ok, match_nx;

	assign v = element_value[VALUE_BITS-1:0];
	assign v33 = 33'(v);
	assign mag33 = v[VALUE_BITS-1] ? -v33 : v33;
	assign e0 = $signed(buf_q[0][32:0] & 33'h0ffffffff) - $signed({buf_q[0][31], 32'd0});
	assign e1 = $signed({buf_q[1][31], buf_q[1][31:0]});
	assign e2 = $signed({buf_q[2][31], buf_q[2][31:0]});
	assign b15 = 38'(e1) * 38'sd15;

	always_comb begin
		cnt_ok = !buf_q[0][32] && (sum_q == SUM_W'(e0));
		like_ok = expected_length == 4'd3 && cnt_q == LEN_W'(3) && !buf_q[0][32]
			&& e0 == 33'sd0 && !buf_q[1][32] && !buf_q[2][32]
			&& !e1[32] && !e2[32];
		match_nx = (cmd.cmp_first ? (dlen_rd == cnt_q) : match_q)
			&& (cnt_q == '0 || drd == buf_q[cmd.elem]);
		sts.special = zero_q || (field_kind == KIND_COUNT && cnt_ok)
			|| (field_kind == KIND_LIKE && like_ok);
		sts.bad = rmiss_q || long_q;
		sts.len = cnt_q;
		sts.all_match = match_nx;
		sts.cur_elem = buf_q[cmd.elem];
	end

	atcd_ram #(.WIDTH(ELEM_W), .DEPTH(DDEPTH)) u_dict (
		.clk(clk), .we(cmd.wr_en), .waddr({cmd.entry, cmd.elem}),
		.wdata(buf_q[cmd.elem]), .raddr({cmd.entry, cmd.elem}), .rdata(drd)
	);

	atcd_ram #(.WIDTH(LEN_W), .DEPTH(DICT_ENTRIES)) u_len (
		.clk(clk), .we(cmd.wr_en && cmd.elem == '0), .waddr(cmd.entry),
		.wdata(cnt_q), .raddr(cmd.entry), .rdata(dlen_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.collect && cnt_q < LEN_W'(MAX_LEN))
			buf_q[cnt_q[IDX_W-1:0]] <= element_missing ? {1'b1, 32'd0} : {1'b0, 32'(v)};
		if (cmd.collect) pos_q <= sample_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; sum_q <= '0; zero_q <= 1'b1; maxmag_q <= '0;
			long_q <= 1'b0; rmiss_q <= 1'b0; match_q <= 1'b0;
		end else begin
			if (cmd.cmp_en)
				match_q <= match_nx;
			if (cmd.clear) begin
				cnt_q <= '0; sum_q <= '0; zero_q <= 1'b1; maxmag_q <= '0;
				long_q <= 1'b0; rmiss_q <= 1'b0;
			end else if (cmd.collect) begin
				if (record_missing) rmiss_q <= 1'b1;
				if (cnt_q < LEN_W'(MAX_LEN)) begin
					cnt_q <= cnt_q + 1'b1;
					if (!element_missing) begin
						sum_q <= sum_q + SUM_W'(v);
						if (v != 0) zero_q <= 1'b0;
						if (mag33[31:0] > maxmag_q) maxmag_q <= mag33[31:0];
					end
				end else long_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			position <= pos_q;
			tip <= TIP_GEN; payload_a <= '0; payload_b <= '0; payload_count <= '0;
			uses_dict <= 1'b0; dict_id <= '0; dict_new <= 1'b0; entry_width <= '0;
			dict_full <= 1'b0; element_sum <= '0; sum_valid <= 1'b0;
			if (sts.bad) begin
				uses_dict <= 1'b1; dict_id <= 8'hFF;
			end else begin
				sum_valid <= 1'b1; element_sum <= sum_q;
				if (zero_q) tip <= TIP_ZERO;
				else if (field_kind == KIND_COUNT && cnt_ok) begin
					if (sum_q == 36'sd2) tip <= TIP_SP1;
					else begin
						tip <= TIP_SP2; payload_a <= sum_q[31:0]; payload_count <= 2'd1;
					end
				end else if (field_kind == KIND_LIKE && like_ok) begin
					payload_a <= e1[31:0];
					if (b15 == 38'(e2)) begin
						tip <= TIP_SP2; payload_count <= 2'd1;
					end else begin
						tip <= TIP_SP1; payload_b <= e2[31:0]; payload_count <= 2'd2;
					end
				end else if (cmd.full) dict_full <= 1'b1;
				else begin
					uses_dict <= 1'b1; dict_id <= 8'(cmd.entry); dict_new <= !cmd.hit;
					if (!cmd.hit)
						entry_width <= maxmag_q < 32'hFF ? 2'd0 :
							(maxmag_q < 32'hFFFF ? 2'd1 : 2'd2);
				end
			end
		end
	end
endmodule

FILE: rtl/core/atcd_ctrl.sv
// Controller: collection, dictionary search, insertion and result handshake.
module atcd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic last_element,
	output logic m_tvalid,
	input logic m_tready,
	input atcd_pkg::sts_t sts,
	output atcd_pkg::cmd_t cmd
);
	import atcd_pkg::*;

	localparam logic [2:0] ST_COLLECT = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_CMP = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0] st_q;
	logic [FILL_W-1:0] fill_q, ent_q;
	logic [LEN_W-1:0] el_q;
	logic hit_q, full_q;
	logic last_el;

	assign s_tready = st_q == ST_COLLECT;
	assign last_el = (el_q + 1'b1 >= sts.len) || sts.len == '0;

	always_comb begin
		cmd = '0;
		cmd.entry = ent_q[ID_W-1:0];
		cmd.elem = el_q[IDX_W-1:0];
		cmd.hit = hit_q;
		cmd.full = full_q;
		cmd.collect = s_tvalid && s_tready;
		cmd.cmp_en = st_q == ST_CMP;
		cmd.cmp_first = el_q == '0;
		cmd.wr_en = st_q == ST_WRITE;
		cmd.emit = st_q == ST_EMIT && (!m_tvalid || m_tready);
		cmd.clear = cmd.emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_COLLECT; fill_q <= '0; ent_q <= '0; el_q <= '0;
			hit_q <= 1'b0; full_q <= 1'b0; m_tvalid <= 1'b0;
		end else begin
			if (cmd.emit) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			case (st_q)
				ST_COLLECT: if (cmd.collect && last_element) st_q <= ST_DECIDE;
				ST_DECIDE: begin
					ent_q <= '0; el_q <= '0; hit_q <= 1'b0; full_q <= 1'b0;
					if (sts.bad || sts.special) st_q <= ST_EMIT;
					else if (fill_q == '0) st_q <= ST_WRITE;
					else st_q <= ST_READ;
				end
				ST_READ: st_q <= ST_CMP;
				ST_CMP: begin
					if (!last_el && (el_q == '0 || sts.all_match || 1'b1)) begin
						el_q <= el_q + 1'b1; st_q <= ST_READ;
					end else begin
						el_q <= '0;
						if (sts.all_match || (el_q == '0 && sts.len == '0 && sts.all_match))
							begin hit_q <= 1'b1; st_q <= ST_EMIT; end
						else if (ent_q + 1'b1 < fill_q) begin
							ent_q <= ent_q + 1'b1; st_q <= ST_READ;
						end else if (fill_q < FILL_W'(DICT_ENTRIES)) begin
							ent_q <= fill_q; st_q <= ST_WRITE;
						end else begin
							full_q <= 1'b1; st_q <= ST_EMIT;
						end
					end
				end
				ST_WRITE: begin
					if (last_el) begin
						el_q <= '0; fill_q <= fill_q + 1'b1; st_q <= ST_EMIT;
					end else el_q <= el_q + 1'b1;
				end
				ST_EMIT: if (cmd.emit) st_q <= ST_COLLECT;
				default: st_q <= ST_COLLECT;
			endcase
		end
	end

	`include "array_tip_classifier_with_dictionary_unit_assert.svh"
	`ATC_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FILL_W'(DICT_ENTRIES))
	`ATC_ASSERT_IMP(a_no_take_busy, st_q != ST_COLLECT, !s_tready)
	`ATC_ASSERT_NXT(a_emit_valid, cmd.emit, m_tvalid)
endmodule
